/* sv/pps_pkg.sv */
package pps_pkg;

    localparam int MAX_WIDTH  = 1024;
    localparam int MAX_HEIGHT = 512;
    localparam int FRAC_BITS  = 8;

    localparam int COL_W  = 10;
    localparam int ROW_W  = 9;
    localparam int ADDR_W = COL_W + ROW_W;
    localparam int CFG_W  = 18;
    localparam int CIDX_W = 3;

    // numerator magnitude: 16x18 product plus 18x16 product, one bit of growth
    localparam int NUM_W  = 35;
    localparam int DEN_W  = 16 + FRAC_BITS;
    localparam int QCNT_W = 6;

    localparam logic [1:0] OP_PROJECT = 2'd0;
    localparam logic [1:0] OP_READ    = 2'd1;
    localparam logic [1:0] OP_CLEAR   = 2'd2;
    // unused opcode, also marks a rejected point in the back end
    localparam logic [1:0] OP_NONE    = 2'd3;

    localparam logic [CIDX_W-1:0] REG_FOCAL_X  = 3'd0;
    localparam logic [CIDX_W-1:0] REG_FOCAL_Y  = 3'd1;
    localparam logic [CIDX_W-1:0] REG_CENTRE_X = 3'd2;
    localparam logic [CIDX_W-1:0] REG_CENTRE_Y = 3'd3;
    localparam logic [CIDX_W-1:0] REG_WIDTH    = 3'd4;
    localparam logic [CIDX_W-1:0] REG_HEIGHT   = 3'd5;

    typedef struct packed {
        logic [COL_W-1:0] pixel_col;
        logic [ROW_W-1:0] pixel_row;
        logic             written;
        logic [23:0]      colour;
    } res_t;

endpackage

/* sv/pps_divider.sv */
// restoring divider, one quotient bit per cycle
module pps_divider
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            start,
    input  logic [pps_pkg::NUM_W-1:0]       num,
    input  logic [pps_pkg::DEN_W-1:0]       den,
    output logic                            done,
    output logic [pps_pkg::NUM_W-1:0]       quot
);

    logic [pps_pkg::NUM_W-1:0]   q_reg, q_next;
    logic [pps_pkg::DEN_W:0]     r_reg, r_next;
    logic [pps_pkg::DEN_W-1:0]   d_reg, d_next;
    logic [pps_pkg::QCNT_W-1:0]  cnt_reg, cnt_next;
    logic                        busy_reg, busy_next;
    logic                        done_reg, done_next;
    logic [pps_pkg::DEN_W:0]     trial;

    // one shift-subtract step
    always_comb
    begin
        q_next    = q_reg;
        r_next    = r_reg;
        d_next    = d_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        trial     = {r_reg[pps_pkg::DEN_W-1:0], q_reg[pps_pkg::NUM_W-1]};
        if (start)
        begin
            q_next    = num;
            r_next    = '0;
            d_next    = den;
            cnt_next  = pps_pkg::QCNT_W'(pps_pkg::NUM_W);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (trial >= {1'b0, d_reg})
            begin
                r_next = trial - {1'b0, d_reg};
                q_next = {q_reg[pps_pkg::NUM_W-2:0], 1'b1};
            end
            else
            begin
                r_next = trial;
                q_next = {q_reg[pps_pkg::NUM_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == pps_pkg::QCNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        q_reg <= q_next;
        r_reg <= r_next;
        d_reg <= d_next;
    end

    assign done = done_reg;
    assign quot = q_reg;

endmodule

/* sv/pps_front.sv */
// accepts transactions, checks point validity, builds both numerators
module pps_front
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_fire,
    input  logic [1:0]                    opcode,
    input  logic [15:0]                   point_x_mm,
    input  logic [15:0]                   point_y_mm,
    input  logic [15:0]                   point_z_mm,
    input  logic                          point_bad,
    input  logic [23:0]                   colour,
    input  logic [pps_pkg::COL_W-1:0]     read_col,
    input  logic [pps_pkg::ROW_W-1:0]     read_row,
    input  logic [pps_pkg::CFG_W-1:0]     focal_x,
    input  logic [pps_pkg::CFG_W-1:0]     focal_y,
    input  logic [pps_pkg::CFG_W-1:0]     centre_x,
    input  logic [pps_pkg::CFG_W-1:0]     centre_y,
    output logic                          busy,
    output logic                          q_valid,
    input  logic                          q_ready,
    output logic [1:0]                    q_kind,
    output logic                          q_reject,
    output logic [pps_pkg::NUM_W-1:0]     q_col_mag,
    output logic [pps_pkg::NUM_W-1:0]     q_row_mag,
    output logic [pps_pkg::DEN_W-1:0]     q_den,
    output logic [23:0]                   q_colour,
    output logic [pps_pkg::COL_W-1:0]     q_rd_col,
    output logic [pps_pkg::ROW_W-1:0]     q_rd_row
);

    // stage 1 registers the products, stage 2 sums into the queue slot
    logic               s1_valid_reg;
    logic signed [34:0] px_reg, py_reg, cx_reg, cy_reg;
    logic [1:0]         s1_kind_reg;
    logic               s1_rej_reg;
    logic [15:0]        s1_z_reg;
    logic [23:0]        s1_col_reg;
    logic [pps_pkg::COL_W-1:0] s1_rc_reg;
    logic [pps_pkg::ROW_W-1:0] s1_rr_reg;

    logic               q_valid_reg;
    logic signed [35:0] ncol, nrow;

    assign busy = s1_valid_reg | q_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else if (in_fire)
            s1_valid_reg <= 1'b1;
        else if (!q_valid_reg)
            s1_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            px_reg <= 35'($signed(point_x_mm) * $signed({1'b0, focal_x}));
            py_reg <= 35'($signed(point_y_mm) * $signed({1'b0, focal_y}));
            cx_reg <= 35'($signed(point_z_mm) * $signed({1'b0, centre_x}));
            cy_reg <= 35'($signed(point_z_mm) * $signed({1'b0, centre_y}));
            s1_kind_reg <= opcode;
            s1_rej_reg  <= point_bad | point_z_mm[15] | (point_z_mm == 16'd0);
            s1_z_reg    <= point_z_mm;
            s1_col_reg  <= colour;
            s1_rc_reg   <= read_col;
            s1_rr_reg   <= read_row;
        end
    end

    // numerators and their magnitudes
    assign ncol = 36'(px_reg) + 36'(cx_reg);
    assign nrow = 36'(py_reg) + 36'(cy_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            q_valid_reg <= 1'b0;
        else if (s1_valid_reg && !q_valid_reg)
            q_valid_reg <= 1'b1;
        else if (q_ready)
            q_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (s1_valid_reg && !q_valid_reg)
        begin
            q_kind    <= s1_kind_reg;
            q_reject  <= s1_rej_reg;
            q_col_mag <= ncol[35] ? 35'(-ncol) : 35'(ncol);
            q_row_mag <= nrow[35] ? 35'(-nrow) : 35'(nrow);
            q_den     <= {s1_z_reg, {pps_pkg::FRAC_BITS{1'b0}}};
            q_colour  <= s1_col_reg;
            q_rd_col  <= s1_rc_reg;
            q_rd_row  <= s1_rr_reg;
        end
    end

    assign q_valid = q_valid_reg;

endmodule

/* sv/pps_back.sv */
// divides, clamps, owns the frame store, runs clear sweeps
module pps_back
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          q_valid,
    output logic                          q_ready,
    input  logic [1:0]                    q_kind,
    input  logic                          q_reject,
    input  logic [pps_pkg::NUM_W-1:0]     q_col_mag,
    input  logic [pps_pkg::NUM_W-1:0]     q_row_mag,
    input  logic [pps_pkg::DEN_W-1:0]     q_den,
    input  logic [23:0]                   q_colour,
    input  logic [pps_pkg::COL_W-1:0]     q_rd_col,
    input  logic [pps_pkg::ROW_W-1:0]     q_rd_row,
    input  logic [10:0]                   image_width,
    input  logic [9:0]                    image_height,
    output logic                          out_valid,
    input  logic                          out_ready,
    output pps_pkg::res_t                 res
);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_DIVC  = 3'd1;
    localparam logic [2:0] ST_DIVR  = 3'd2;
    localparam logic [2:0] ST_READ  = 3'd3;
    localparam logic [2:0] ST_CLEAR = 3'd4;
    localparam logic [2:0] ST_OUT   = 3'd5;
    localparam logic [2:0] ST_WAIT  = 3'd6;
    localparam logic [2:0] ST_INIT  = 3'd7;

    logic [2:0] st_reg, st_next;
    logic [pps_pkg::ADDR_W-1:0] clr_reg;
    logic [23:0] mem [0:(1<<pps_pkg::ADDR_W)-1];
    logic [23:0] rdata_reg;
    pps_pkg::res_t res_reg;
    logic ov_reg;
    logic [1:0] kind_reg;
    logic [pps_pkg::NUM_W-1:0] rowmag_reg;
    logic [pps_pkg::DEN_W-1:0] den_reg;
    logic [23:0] colour_reg;
    logic [pps_pkg::COL_W-1:0] col_reg;
    logic [pps_pkg::ROW_W-1:0] row_reg;

    logic div_start, div_done;
    logic [pps_pkg::NUM_W-1:0] div_num, div_q;
    logic [10:0] wlim;
    logic [9:0]  hlim;
    logic [pps_pkg::COL_W-1:0] col_cl;
    logic [pps_pkg::ROW_W-1:0] row_cl;
    logic sweep;

    // active size saturation
    assign wlim = (image_width == 11'd0) ? 11'd1 :
                  (image_width > 11'(pps_pkg::MAX_WIDTH)) ? 11'(pps_pkg::MAX_WIDTH) : image_width;
    assign hlim = (image_height == 10'd0) ? 10'd1 :
                  (image_height > 10'(pps_pkg::MAX_HEIGHT)) ? 10'(pps_pkg::MAX_HEIGHT) : image_height;

    // quotient magnitude equals abs of truncated quotient; clamp to limit-1
    assign col_cl = (div_q > pps_pkg::NUM_W'(wlim - 11'd1)) ?
                    pps_pkg::COL_W'(wlim - 11'd1) : pps_pkg::COL_W'(div_q);
    assign row_cl = (div_q > pps_pkg::NUM_W'(hlim - 10'd1)) ?
                    pps_pkg::ROW_W'(hlim - 10'd1) : pps_pkg::ROW_W'(div_q);

    // store blanking after reset or on a clear transaction
    assign sweep = (st_reg == ST_CLEAR) || (st_reg == ST_INIT);

    assign q_ready = (st_reg == ST_IDLE);
    assign div_start = (st_reg == ST_IDLE && q_valid && q_kind == pps_pkg::OP_PROJECT && !q_reject)
                     || (st_reg == ST_DIVC && div_done);
    assign div_num = (st_reg == ST_IDLE) ? q_col_mag : rowmag_reg;

    pps_divider u_div
    (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (div_num),
        .den   ((st_reg == ST_IDLE) ? q_den : den_reg),
        .done  (div_done),
        .quot  (div_q)
    );

    // sequencer
    always_comb
    begin
        st_next = st_reg;
        unique case (st_reg)
            ST_IDLE:
                if (q_valid)
                begin
                    if (q_kind == pps_pkg::OP_PROJECT && !q_reject)
                        st_next = ST_DIVC;
                    else if (q_kind == pps_pkg::OP_READ)
                        st_next = ST_READ;
                    else if (q_kind == pps_pkg::OP_CLEAR)
                        st_next = ST_CLEAR;
                    else
                        st_next = ST_OUT;
                end
            ST_DIVC:  if (div_done) st_next = ST_DIVR;
            ST_DIVR:  if (div_done) st_next = ST_OUT;
            ST_READ:  st_next = ST_OUT;
            ST_CLEAR: if (&clr_reg) st_next = ST_OUT;
            ST_OUT:   if (!ov_reg) st_next = ST_WAIT;
            ST_WAIT:  if (!ov_reg) st_next = ST_IDLE;
            ST_INIT:  if (&clr_reg) st_next = ST_IDLE;
            default:  st_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg  <= ST_INIT;
            clr_reg <= '0;
            ov_reg  <= 1'b0;
        end
        else
        begin
            st_reg <= st_next;
            if (sweep)
                clr_reg <= clr_reg + 1'b1;
            if (st_reg == ST_OUT && !ov_reg)
                ov_reg <= 1'b1;
            else if (out_ready)
                ov_reg <= 1'b0;
        end
    end

    // transaction capture and result assembly
    always_ff @(posedge clk)
    begin
        if (st_reg == ST_IDLE && q_valid)
        begin
            kind_reg   <= (q_kind == pps_pkg::OP_PROJECT && q_reject) ? pps_pkg::OP_NONE : q_kind;
            rowmag_reg <= q_row_mag;
            den_reg    <= q_den;
            colour_reg <= q_colour;
            col_reg    <= q_rd_col;
            row_reg    <= q_rd_row;
        end
        if (st_reg == ST_DIVC && div_done)
            col_reg <= col_cl;
        if (st_reg == ST_DIVR && div_done)
            row_reg <= row_cl;
        if (st_reg == ST_OUT && !ov_reg)
        begin
            res_reg.pixel_col <= (kind_reg == pps_pkg::OP_PROJECT) ? col_reg : '0;
            res_reg.pixel_row <= (kind_reg == pps_pkg::OP_PROJECT) ? row_reg : '0;
            res_reg.written   <= (kind_reg == pps_pkg::OP_PROJECT);
            res_reg.colour    <= (kind_reg == pps_pkg::OP_READ) ? rdata_reg : 24'd0;
        end
    end

    // frame store, one write or read port per cycle
    always_ff @(posedge clk)
    begin
        if (sweep)
            mem[clr_reg] <= 24'd0;
        else if (st_reg == ST_OUT && !ov_reg && kind_reg == pps_pkg::OP_PROJECT)
            mem[{row_reg, col_reg}] <= colour_reg;
        if (st_reg == ST_READ)
            rdata_reg <= mem[{row_reg, col_reg}];
    end

    assign out_valid = ov_reg;
    assign res = res_reg;

endmodule

/* sv/point_projection_splatter_core.sv */
// point projection: two front stages, then two 35-step serial divisions,
// column then row; read: the front stages and one store read; rejected
// point, no-op: the front stages only; clear: the whole store, one entry a cycle.
// one transaction in the back end at a time: the next is taken once the last
// result is accepted. reset: async active low, registers to defaults, then a
// sweep blanks the store before the first transaction is served.
module point_projection_splatter_core
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [1:0]  opcode,
    input  logic [15:0] point_x_mm,
    input  logic [15:0] point_y_mm,
    input  logic [15:0] point_z_mm,
    input  logic        point_bad,
    input  logic [7:0]  red,
    input  logic [7:0]  green,
    input  logic [7:0]  blue,
    input  logic [9:0]  read_col,
    input  logic [8:0]  read_row,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [9:0]  pixel_col,
    output logic [8:0]  pixel_row,
    output logic        written,
    output logic [7:0]  out_red,
    output logic [7:0]  out_green,
    output logic [7:0]  out_blue,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [17:0] cfg_data
);

    logic [17:0] fx_reg, fy_reg, cxr_reg, cyr_reg;
    logic [10:0] w_reg;
    logic [9:0]  h_reg;
    logic front_busy, q_valid, q_ready, q_reject;
    logic [1:0] q_kind;
    logic [pps_pkg::NUM_W-1:0] q_cm, q_rm;
    logic [pps_pkg::DEN_W-1:0] q_den;
    logic [23:0] q_colour;
    logic [9:0] q_rc;
    logic [8:0] q_rr;
    pps_pkg::res_t res;
    logic in_fire;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fx_reg <= 18'd149152; fy_reg <= 18'd149169;
            cxr_reg <= 18'd80139; cyr_reg <= 18'd61042;
            w_reg <= 11'd640; h_reg <= 10'd480;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                pps_pkg::REG_FOCAL_X:  fx_reg  <= cfg_data;
                pps_pkg::REG_FOCAL_Y:  fy_reg  <= cfg_data;
                pps_pkg::REG_CENTRE_X: cxr_reg <= cfg_data;
                pps_pkg::REG_CENTRE_Y: cyr_reg <= cfg_data;
                pps_pkg::REG_WIDTH:    w_reg   <= cfg_data[10:0];
                pps_pkg::REG_HEIGHT:   h_reg   <= cfg_data[9:0];
                default: ;
            endcase
        end
    end

    assign in_ready = !front_busy;
    assign in_fire  = in_valid && in_ready;

    pps_front u_front
    (
        .clk(clk), .rst_n(rst_n), .in_fire(in_fire), .opcode(opcode),
        .point_x_mm(point_x_mm), .point_y_mm(point_y_mm), .point_z_mm(point_z_mm),
        .point_bad(point_bad), .colour({red, green, blue}),
        .read_col(read_col), .read_row(read_row),
        .focal_x(fx_reg), .focal_y(fy_reg), .centre_x(cxr_reg), .centre_y(cyr_reg),
        .busy(front_busy), .q_valid(q_valid), .q_ready(q_ready),
        .q_kind(q_kind), .q_reject(q_reject),
        .q_col_mag(q_cm), .q_row_mag(q_rm), .q_den(q_den), .q_colour(q_colour),
        .q_rd_col(q_rc), .q_rd_row(q_rr)
    );

    pps_back u_back
    (
        .clk(clk), .rst_n(rst_n), .q_valid(q_valid), .q_ready(q_ready),
        .q_kind(q_kind), .q_reject(q_reject),
        .q_col_mag(q_cm), .q_row_mag(q_rm), .q_den(q_den), .q_colour(q_colour),
        .q_rd_col(q_rc), .q_rd_row(q_rr), .image_width(w_reg), .image_height(h_reg),
        .out_valid(out_valid), .out_ready(out_ready), .res(res)
    );

    assign pixel_col = res.pixel_col;
    assign pixel_row = res.pixel_row;
    assign written   = res.written;
    assign out_red   = res.colour[23:16];
    assign out_green = res.colour[15:8];
    assign out_blue  = res.colour[7:0];

    // a stalled result stays valid and keeps its written flag
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(written))
        else $error("result changed while stalled");

    // a written result never carries colour
    a_wr: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && written |-> {out_red, out_green, out_blue} == 24'd0)
        else $error("written result with colour");

endmodule
